>>> rtl/core/dmxr_pkg.sv
// Shared types and constants for the DMX512 frame receiver.
package dmxr_pkg;

  localparam int STORE_DEPTH = 512;
  localparam int ADDR_W      = 9;
  localparam int FILL_W      = 10;
  localparam int POS_W       = 11;
  localparam int CNT_W       = 32;
  localparam int DATA_W      = 8;
  localparam int WORD_W      = 12;
  localparam int INDEX_W     = 10;
  localparam int BREAK_BIT   = 10;

  localparam logic signed [POS_W-1:0] POS_IDLE  = -11'sd2;
  localparam logic signed [POS_W-1:0] POS_ARMED = -11'sd1;
  localparam logic signed [POS_W-1:0] POS_START = 11'sd0;
  localparam logic signed [POS_W-1:0] POS_ONE   = 11'sd1;

  localparam logic REQ_WORD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // one queued operation: memory access plus the result fields known up front
  typedef struct packed {
    logic                      mem_wr;
    logic                      mem_rd;
    logic [ADDR_W-1:0]         addr;
    logic [DATA_W-1:0]         wdata;
    logic                      index_error;
    logic signed [POS_W-1:0]   position;
    logic [CNT_W-1:0]          word_count;
    logic [CNT_W-1:0]          break_total;
  } op_t;

endpackage

>>> rtl/core/dmx512_frame_receiver_top.sv
// Top level of the DMX512 frame receiver.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+--------------------------------------------
//  s_*     | in  | s_tvalid/s_tready | received UART word or channel read request
//  m_*     | out | m_tvalid/m_tready | one result word per accepted input word
//
//  Throughput: one word per cycle in both directions while neither side stalls; each
//  word does at most one access to the single-port channel store in the back end.
//  Each accepted word is registered in the queue, then in the output stage.
//  Reset clears frame state, counters, fill count, queue and output stage; the
//  store itself is not swept: slots never written since reset read as zero.
//  Either side may stall; the 4-word queue and output register decouple them.
module dmx512_frame_receiver_top #(
  parameter int CHANNEL_COUNT = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [11:0] rx_word, [21:12] channel_index, [23:22] zero
  input  logic [0:0]  s_tuser,   // [0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // [7:0] channel_value, [18:8] receive_position,
                                 // [50:19] word_count, [82:51] break_total, [87:83] zero
  output logic [0:0]  m_tuser    // [0] index_error
);

  logic                              q_full;
  logic                              push;
  dmxr_pkg::op_t                     push_op;
  logic                              pop;
  logic                              head_valid;
  dmxr_pkg::op_t                     head_op;
  logic [dmxr_pkg::DATA_W-1:0]       channel_value;
  logic                              index_error;
  logic signed [dmxr_pkg::POS_W-1:0] receive_position;
  logic [dmxr_pkg::CNT_W-1:0]        word_count;
  logic [dmxr_pkg::CNT_W-1:0]        break_total;

  // front: frame state machine and counters, one word per cycle while the queue is not full
  dmxr_front #(
    .CHANNEL_COUNT(CHANNEL_COUNT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .req_type     (s_tuser[0]),
    .rx_word      (s_tdata[11:0]),
    .channel_index(s_tdata[21:12]),
    .q_full       (q_full),
    .push         (push),
    .op           (push_op)
  );

  // operations stay in order, so a read always sees earlier writes
  dmxr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_op   (push_op),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_op   (head_op)
  );

  // back: store access and output register
  dmxr_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head_valid      (head_valid),
    .head_op         (head_op),
    .pop             (pop),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .channel_value   (channel_value),
    .index_error     (index_error),
    .receive_position(receive_position),
    .word_count      (word_count),
    .break_total     (break_total)
  );

  assign m_tdata = {5'b0, break_total, word_count, receive_position, channel_value};
  assign m_tuser = index_error;

endmodule

>>> rtl/core/dmxr_front.sv
// Front end: frame tracking, counters, fill count, builds memory operations.
module dmxr_front #(
  parameter int CHANNEL_COUNT = 512
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          req_type,
  input  logic [dmxr_pkg::WORD_W-1:0]   rx_word,
  input  logic [dmxr_pkg::INDEX_W-1:0]  channel_index,
  input  logic                          q_full,
  output logic                          push,
  output dmxr_pkg::op_t                 op
);

  localparam logic [dmxr_pkg::FILL_W-1:0] CH_LIMIT = dmxr_pkg::FILL_W'(CHANNEL_COUNT);

  logic signed [dmxr_pkg::POS_W-1:0] position, position_next;
  logic [dmxr_pkg::CNT_W-1:0]        words_seen, words_seen_next;
  logic [dmxr_pkg::CNT_W-1:0]        breaks_seen, breaks_seen_next;
  // slots below fill have been written since reset; the rest still read zero
  logic [dmxr_pkg::FILL_W-1:0]       fill, fill_next;
  logic [dmxr_pkg::FILL_W-1:0]       slot;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;
  assign slot     = position[dmxr_pkg::FILL_W-1:0];

  always_comb begin
    position_next    = position;
    words_seen_next  = words_seen;
    breaks_seen_next = breaks_seen;
    fill_next        = fill;
    op               = '0;
    if (req_type == dmxr_pkg::REQ_WORD) begin
      words_seen_next = words_seen + 32'd1;
      priority if (rx_word[dmxr_pkg::BREAK_BIT]) begin
        position_next    = dmxr_pkg::POS_ARMED;
        breaks_seen_next = breaks_seen + 32'd1;
      end else if (position == dmxr_pkg::POS_ARMED) begin
        position_next = (rx_word == '0) ? dmxr_pkg::POS_START : dmxr_pkg::POS_IDLE;
      end else if (!position[dmxr_pkg::POS_W-1] && slot < CH_LIMIT) begin
        op.mem_wr     = 1'b1;
        op.addr       = slot[dmxr_pkg::ADDR_W-1:0];
        op.wdata      = rx_word[dmxr_pkg::DATA_W-1:0];
        position_next = position + dmxr_pkg::POS_ONE;
        if (slot == fill) begin
          fill_next = fill + 10'd1;
        end
      end else begin
        position_next = position;
      end
    end else begin
      if (channel_index < CH_LIMIT) begin
        op.mem_rd = channel_index < fill;
        op.addr   = channel_index[dmxr_pkg::ADDR_W-1:0];
      end else begin
        op.index_error = 1'b1;
      end
    end
    op.position    = position_next;
    op.word_count  = words_seen_next;
    op.break_total = breaks_seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= dmxr_pkg::POS_IDLE;
      words_seen  <= '0;
      breaks_seen <= '0;
      fill        <= '0;
    end else if (push) begin
      position    <= position_next;
      words_seen  <= words_seen_next;
      breaks_seen <= breaks_seen_next;
      fill        <= fill_next;
    end
  end

endmodule

>>> rtl/core/dmxr_queue.sv
// Small FIFO of memory operations between front and back.
module dmxr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dmxr_pkg::op_t push_op,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output dmxr_pkg::op_t head_op
);

  localparam logic [dmxr_pkg::QPTR_W:0] QDEPTH = (dmxr_pkg::QPTR_W + 1)'(dmxr_pkg::QUEUE_DEPTH);

  dmxr_pkg::op_t                 slots [dmxr_pkg::QUEUE_DEPTH];
  logic [dmxr_pkg::QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [dmxr_pkg::QPTR_W:0]     count;

  assign full       = count == QDEPTH;
  assign head_valid = count != '0;
  assign head_op    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop)  rd_ptr <= rd_ptr + 2'd1;
      if (push && !pop)      count <= count + 3'd1;
      else if (pop && !push) count <= count - 3'd1;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !head_valid))
    else $error("queue pop while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 3'd1)
    else $error("queue count did not grow on push");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count != QDEPTH && count != '0) |-> wr_ptr != rd_ptr)
    else $error("queue pointers disagree with count");
`endif

endmodule

>>> rtl/core/dmxr_back.sv
// Back end: channel store access and registered result stage.
module dmxr_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              head_valid,
  input  dmxr_pkg::op_t                     head_op,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dmxr_pkg::DATA_W-1:0]       channel_value,
  output logic                              index_error,
  output logic signed [dmxr_pkg::POS_W-1:0] receive_position,
  output logic [dmxr_pkg::CNT_W-1:0]        word_count,
  output logic [dmxr_pkg::CNT_W-1:0]        break_total
);

  logic [dmxr_pkg::DATA_W-1:0] store [dmxr_pkg::STORE_DEPTH];
  logic [dmxr_pkg::DATA_W-1:0] rd_data;
  logic                        use_mem;

  assign pop           = head_valid && (!out_valid || out_ready);
  assign channel_value = use_mem ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (pop && head_op.mem_wr) begin
      store[head_op.addr] <= head_op.wdata;
    end
    if (pop && head_op.mem_rd) begin
      rd_data <= store[head_op.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      use_mem          <= head_op.mem_rd;
      index_error      <= head_op.index_error;
      receive_position <= head_op.position;
      word_count       <= head_op.word_count;
      break_total      <= head_op.break_total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

>>> test/tb_dmx512_frame_receiver_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the DMX512 frame receiver: stream driver, monitor and scoreboard.
module tb_dmx512_frame_receiver_top;

  localparam int CHANNELS    = 512;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;     // long output hold-off, fills the block

  localparam logic [dmxr_pkg::WORD_W-1:0] START_CODE = '0;
  localparam logic [dmxr_pkg::WORD_W-1:0] BREAK_MASK = 12'h400;

  // one input word as the sender sees it
  typedef struct {
    logic                         req_type;
    logic [dmxr_pkg::WORD_W-1:0]  rx_word;
    logic [dmxr_pkg::INDEX_W-1:0] channel_index;
  } rx_item_t;

  // one result word as the block should report it
  typedef struct {
    logic [dmxr_pkg::DATA_W-1:0]       channel_value;
    logic                              index_error;
    logic signed [dmxr_pkg::POS_W-1:0] position;
    logic [dmxr_pkg::CNT_W-1:0]        word_count;
    logic [dmxr_pkg::CNT_W-1:0]        break_total;
  } rx_result_t;

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT
  // ---------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;    // [11:0] rx_word, [21:12] channel_index, [23:22] zero
  logic [0:0]  s_tuser = '0;    // [0] req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;         // [7:0] value, [18:8] position, [50:19] words, [82:51] breaks
  logic [0:0]  m_tuser;         // [0] index_error

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dmx512_frame_receiver_top #(
    .CHANNEL_COUNT(CHANNELS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: frame position, channel bytes, the two counters
  // ---------------------------------------------------------------------------
  logic signed [dmxr_pkg::POS_W-1:0] frame_pos;
  logic [dmxr_pkg::DATA_W-1:0]       slot_bytes [CHANNELS];
  logic [dmxr_pkg::CNT_W-1:0]        words_total;
  logic [dmxr_pkg::CNT_W-1:0]        breaks_total;

  // what the run has exercised, for the closing summary
  int frames_opened, bytes_dropped, reads_done, reads_out_of_range;

  rx_item_t   pending_words[$];     // filled by the stimulus, drained by the driver
  rx_result_t expected_results[$];  // one entry per accepted input word
  rx_item_t   bus_item;             // the word currently offered on s_*
  rx_result_t seen_expect;

  int   pushed_words;
  int   accepted_total;
  int   results_checked;
  int   mismatches;
  int   stall_cycles;
  int   cycle_cnt;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   hold_left;
  bit   hold_done;
  bit   hold_armed;
  int   hold_mark;

  // Apply one input word to the predictor state and return the result it causes.
  function automatic rx_result_t predict_frame_result(rx_item_t it);
    rx_result_t r;
    r.channel_value = '0;
    r.index_error   = 1'b0;
    if (it.req_type == dmxr_pkg::REQ_WORD) begin
      words_total = words_total + 1;
      if (it.rx_word[dmxr_pkg::BREAK_BIT]) begin
        // break wins over every other bit, in any state
        frame_pos    = dmxr_pkg::POS_ARMED;
        breaks_total = breaks_total + 1;
      end else if (frame_pos == dmxr_pkg::POS_ARMED) begin
        // only an all-zero word is a valid start code
        if (it.rx_word == START_CODE) begin
          frame_pos = dmxr_pkg::POS_START;
          frames_opened++;
        end else begin
          frame_pos = dmxr_pkg::POS_IDLE;
        end
      end else if (frame_pos >= 0 && frame_pos < CHANNELS) begin
        slot_bytes[frame_pos[dmxr_pkg::ADDR_W-1:0]] = it.rx_word[dmxr_pkg::DATA_W-1:0];
        frame_pos = frame_pos + dmxr_pkg::POS_ONE;
      end else if (frame_pos == CHANNELS) begin
        bytes_dropped++;
      end
    end else begin
      reads_done++;
      if (it.channel_index < CHANNELS) begin
        r.channel_value = slot_bytes[it.channel_index[dmxr_pkg::ADDR_W-1:0]];
      end else begin
        r.index_error = 1'b1;
        reads_out_of_range++;
      end
    end
    r.position    = frame_pos;
    r.word_count  = words_total;
    r.break_total = breaks_total;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued words, predicts each one at its accepting edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(predict_frame_result(bus_item));
        accepted_total <= accepted_total + 1;
      end
      if (s_tvalid && !s_tready) begin
        stall_cycles <= stall_cycles + 1;
      end
      // load the next word once the bus is free
      if (!s_tvalid || s_tready) begin
        if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          bus_item = pending_words.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {2'b00, bus_item.channel_index, bus_item.rx_word};
          s_tuser  <= bus_item.req_type;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: takes result words and compares them with the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(string field, longint want, longint got);
    if (want != got) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", field, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $error("result word with no prediction waiting");
        end else begin
          seen_expect = expected_results.pop_front();
          check_field("channel_value", seen_expect.channel_value, m_tdata[7:0]);
          check_field("index_error", seen_expect.index_error, m_tuser[0]);
          check_field("receive_position", seen_expect.position, $signed(m_tdata[18:8]));
          check_field("word_count", seen_expect.word_count, m_tdata[50:19]);
          check_field("break_total", seen_expect.break_total, m_tdata[82:51]);
          results_checked++;
        end
      end
      m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Long output hold-off, once, while the sender keeps offering words.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && hold_armed && accepted_total >= hold_mark) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, expected_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_word(logic [dmxr_pkg::WORD_W-1:0] w);
    rx_item_t it;
    it.req_type      = dmxr_pkg::REQ_WORD;
    it.rx_word       = w;
    // don't-care on a word
    it.channel_index = dmxr_pkg::INDEX_W'($urandom_range(0, 1023));
    pending_words.push_back(it);
    pushed_words++;
  endtask

  task automatic push_read(logic [dmxr_pkg::INDEX_W-1:0] idx);
    rx_item_t it;
    it.req_type      = dmxr_pkg::REQ_READ;
    it.rx_word       = dmxr_pkg::WORD_W'($urandom_range(0, 4095));  // don't-care on a read
    it.channel_index = idx;
    pending_words.push_back(it);
    pushed_words++;
  endtask

  // mostly low channels, some anywhere, some around the top of the store
  function automatic logic [dmxr_pkg::INDEX_W-1:0] pick_channel();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return dmxr_pkg::INDEX_W'($urandom_range(0, 63));
    if (r < 85) return dmxr_pkg::INDEX_W'($urandom_range(0, 1023));
    return dmxr_pkg::INDEX_W'($urandom_range(CHANNELS - 12, CHANNELS + 11));
  endfunction

  // break word: flag set, other bits random half the time
  function automatic logic [dmxr_pkg::WORD_W-1:0] pick_break();
    logic [dmxr_pkg::WORD_W-1:0] w;
    w = dmxr_pkg::WORD_W'($urandom_range(0, 4095));
    w[dmxr_pkg::BREAK_BIT] = 1'b1;
    return ($urandom_range(0, 1) == 0) ? BREAK_MASK : w;
  endfunction

  // data word: never a break, error flags on a minority
  function automatic logic [dmxr_pkg::WORD_W-1:0] pick_data();
    logic [dmxr_pkg::WORD_W-1:0] w;
    w = dmxr_pkg::WORD_W'($urandom_range(0, 4095));
    w[dmxr_pkg::BREAK_BIT] = 1'b0;
    if ($urandom_range(0, 99) < 60) w[dmxr_pkg::WORD_W-1:dmxr_pkg::DATA_W] = '0;
    return w;
  endfunction

  // break, zero start code, then data bytes with reads mixed in
  task automatic push_frame(int len, int read_pct);
    push_word(pick_break());
    push_word(START_CODE);
    for (int i = 0; i < len; i++) begin
      push_word(pick_data());
      if ($urandom_range(0, 99) < read_pct) push_read(pick_channel());
    end
  endtask

  task automatic gen_random_traffic(int n);
    int goal, r;
    logic [dmxr_pkg::WORD_W-1:0] w;
    goal = pushed_words + n;
    while (pushed_words < goal) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        push_frame(($urandom_range(0, 9) == 0) ? $urandom_range(25, 120)
                                               : $urandom_range(0, 24), 25);
      end else if (r < 70) begin
        // broken frame: nonzero start code, then data that must be ignored
        push_word(pick_break());
        w = dmxr_pkg::WORD_W'($urandom_range(1, 4095));
        w[dmxr_pkg::BREAK_BIT] = 1'b0;
        if (w == START_CODE) w = 12'h001;
        push_word(w);
        repeat ($urandom_range(0, 6)) push_word(pick_data());
      end else if (r < 85) begin
        repeat ($urandom_range(1, 8)) push_read(pick_channel());
      end else begin
        // noise: anything at all
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 1) == 0) begin
            push_word(dmxr_pkg::WORD_W'($urandom_range(0, 4095)));
          end else begin
            push_read(dmxr_pkg::INDEX_W'($urandom_range(0, 1023)));
          end
        end
      end
    end
  endtask

  // sender pauses until every predicted result has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words.size() != 0 || s_tvalid || expected_results.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    frame_pos    = dmxr_pkg::POS_IDLE;
    words_total  = '0;
    breaks_total = '0;
    for (int i = 0; i < CHANNELS; i++) slot_bytes[i] = '0;

    // phase 1: sender idles 23%, receiver 60%
    send_idle_pct = 23;
    recv_idle_pct = 60;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // store is zero after reset; edges of the index range
    push_read(10'd0);
    push_read(10'd511);
    push_read(10'd512);
    push_read(10'd1023);
    // data while idle is only counted
    push_word(12'h0FF);
    push_word(12'hBFF);
    // start code with a data bit set -> ignore until next break
    push_word(BREAK_MASK);
    push_word(12'h001);
    push_word(12'h055);
    // break with every bit set still arms; framing flag alone spoils the start
    push_word(12'hFFF);
    push_word(12'h100);
    // clean frame; flags on data bytes are stripped
    push_word(BREAK_MASK);
    push_word(START_CODE);
    push_word(12'h000);
    push_word(12'hBFF);
    push_word(12'h0A5);
    push_word(12'h35A);
    push_read(10'd0);
    push_read(10'd1);
    push_read(10'd2);
    push_read(10'd3);
    push_read(10'd4);
    // break in mid-frame re-arms and the next frame overwrites slot 0
    push_word(12'h4AA);
    push_word(START_CODE);
    push_word(12'h07E);
    push_read(10'd0);

    gen_random_traffic(420);
    wait_drained();

    // phase 2: roles swapped
    send_idle_pct = 60;
    recv_idle_pct = 23;
    gen_random_traffic(420);
    wait_drained();

    // phase 3: no idling; output held off during a frame that overruns the store
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_mark  = accepted_total + 80;
    hold_armed = 1'b1;
    push_frame(CHANNELS + 8, 0);
    push_read(10'd511);
    push_read(10'd512);
    push_read(10'd0);
    gen_random_traffic(90);
    wait_drained();

    // late or spurious results would show up here
    repeat (8) @(negedge clk);
    if (expected_results.size() != 0) begin
      mismatches++;
      $error("%0d predicted results never arrived", expected_results.size());
    end

    $display("covered %0d UART words (%0d breaks, %0d frames opened, %0d bytes dropped)",
             words_total, breaks_total, frames_opened, bytes_dropped);
    $display("and %0d reads (%0d out of range); %0d results checked, %0d stall cycles",
             reads_done, reads_out_of_range, results_checked, stall_cycles);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/dmxr_pkg.sv
rtl/core/dmxr_front.sv
rtl/core/dmxr_queue.sv
rtl/core/dmxr_back.sv
rtl/core/dmx512_frame_receiver_top.sv
test/tb_dmx512_frame_receiver_top.sv
